// ===== rtl/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helpers for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int MAX_SENTENCE_LEN_DEF = 128;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    localparam logic [23:0] TYPE_GGA = 24'h474741;
    localparam logic [23:0] TYPE_GSA = 24'h475341;

    localparam logic [4:0] GGA_FIX_FIELD = 5'd6;
    localparam logic [4:0] GSA_FIX_FIELD = 5'd2;
    localparam logic [4:0] COMMA_COUNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_STAR = 2'd1,
        STATUS_BAD_SUM  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_GSA   = 2'd2
    } kind_t;

    typedef struct packed {
        status_t status;
        kind_t   kind;
        logic    has_fix;
    } result_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        if (nibble < 4'd10) begin
            return CHAR_ZERO + {4'd0, nibble};
        end else begin
            return CHAR_UPPER_A + {4'd0, nibble} - 8'd10;
        end
    endfunction

endpackage

// ===== rtl/nsc_rx_stage.sv =====
// ----------------------------------------------------------------------------
// nsc_rx_stage
// Input register that holds one received byte until the tracker consumes it.
// ----------------------------------------------------------------------------
module nsc_rx_stage import nsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    assign s_ready    = !valid_reg || take;
    assign load       = s_valid && s_ready;
    assign valid_next = load || (valid_reg && !take);
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_rx_byte;
        end
    end

endmodule

// ===== rtl/nsc_tracker.sv =====
// ----------------------------------------------------------------------------
// nsc_tracker
// Sentence state: checksum, type characters, comma and field tracking, and
// the result of a sentence when its line feed arrives.
// ----------------------------------------------------------------------------
module nsc_tracker import nsc_pkg::*; #(
    parameter int MAX_SENTENCE_LEN = MAX_SENTENCE_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       emit,
    output result_t    result
);

    typedef struct packed {
        logic        in_sentence;
        logic [7:0]  char_count;
        logic [7:0]  running_xor;
        logic        star_seen;
        logic [7:0]  star_position;
        logic [39:0] last_chars;
        logic [23:0] type_chars;
        logic [4:0]  comma_count;
        logic [7:0]  field_first_char;
        logic [7:0]  field_length;
        logic [7:0]  field_number_value;
        logic        field_open;
        logic        digit_run;
        logic        gga_ok;
        logic        gsa_ok;
        logic [15:0] recv_hex;
    } track_state_t;

    localparam logic [7:0] MAX_LEN = 8'(MAX_SENTENCE_LEN);

    track_state_t st_reg;
    track_state_t st_next;

    function automatic track_state_t close_field(input track_state_t s);
        track_state_t r;
        r = s;
        if (s.field_open) begin
            if (s.comma_count == GGA_FIX_FIELD) begin
                r.gga_ok = (s.field_length == 8'd1) && (s.field_first_char == CHAR_ONE);
            end else if (s.comma_count == GSA_FIX_FIELD) begin
                r.gsa_ok = (s.field_number_value > 8'd1);
            end
            r.field_open = 1'b0;
        end
        return r;
    endfunction

    always_comb begin
        track_state_t nx;
        logic [7:0]   idx;
        logic [4:0]   commas;
        logic [11:0]  scaled;
        logic         star_ok;
        logic [15:0]  want;

        nx      = st_reg;
        idx     = st_reg.char_count;
        commas  = st_reg.comma_count;
        scaled  = '0;
        star_ok = 1'b0;
        want    = '0;
        emit    = 1'b0;
        result  = '{status: STATUS_OK, kind: KIND_OTHER, has_fix: 1'b0};

        if (rx_byte == CHAR_DOLLAR) begin
            nx             = '0;
            nx.in_sentence = 1'b1;
            nx.char_count  = 8'd1;
            nx.last_chars  = {32'd0, rx_byte};
        end else if (st_reg.in_sentence) begin
            if (st_reg.char_count >= MAX_LEN) begin
                nx = '0;
            end else begin
                nx.char_count = idx + 8'd1;
                nx.last_chars = {st_reg.last_chars[31:0], rx_byte};
                if (idx >= 8'd3 && idx <= 8'd5) begin
                    nx.type_chars = {st_reg.type_chars[15:0], rx_byte};
                end

                if (st_reg.star_seen) begin
                    if ({1'b0, idx} == {1'b0, st_reg.star_position} + 9'd1) begin
                        nx.recv_hex = {rx_byte, 8'h00};
                    end else if ({1'b0, idx} == {1'b0, st_reg.star_position} + 9'd2) begin
                        nx.recv_hex[7:0] = rx_byte;
                    end
                end else if (rx_byte == CHAR_STAR) begin
                    nx               = close_field(nx);
                    nx.star_seen     = 1'b1;
                    nx.star_position = idx;
                end else begin
                    if (rx_byte != CHAR_LF) begin
                        nx.running_xor = st_reg.running_xor ^ rx_byte;
                    end
                    if (rx_byte == CHAR_COMMA) begin
                        nx = close_field(nx);
                        if (commas != COMMA_COUNT_MAX) begin
                            commas = commas + 5'd1;
                        end
                        nx.comma_count = commas;
                        if (commas == GSA_FIX_FIELD || commas == GGA_FIX_FIELD) begin
                            nx.field_open         = 1'b1;
                            nx.digit_run          = 1'b1;
                            nx.field_first_char   = '0;
                            nx.field_length       = '0;
                            nx.field_number_value = '0;
                        end
                    end else if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
                        nx = close_field(nx);
                    end else if (st_reg.field_open) begin
                        if (st_reg.field_length == 8'd0) begin
                            nx.field_first_char = rx_byte;
                        end
                        if (st_reg.field_length != 8'hFF) begin
                            nx.field_length = st_reg.field_length + 8'd1;
                        end
                        if (st_reg.digit_run && rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
                            scaled = {1'b0, st_reg.field_number_value, 3'b000}
                                   + {3'b000, st_reg.field_number_value, 1'b0}
                                   + {8'd0, rx_byte[3:0]};
                            nx.field_number_value = (scaled > 12'd255) ? 8'hFF : scaled[7:0];
                        end else begin
                            nx.digit_run = 1'b0;
                        end
                    end
                end

                if (rx_byte == CHAR_LF) begin
                    emit    = 1'b1;
                    star_ok = (nx.char_count >= 8'd5) && (nx.last_chars[39:32] == CHAR_STAR);
                    want    = {hex_char(nx.running_xor[7:4]), hex_char(nx.running_xor[3:0])};
                    if (!star_ok) begin
                        result.status = STATUS_BAD_STAR;
                    end else if (want != nx.recv_hex) begin
                        result.status = STATUS_BAD_SUM;
                    end else if (nx.char_count >= 8'd6) begin
                        if (nx.type_chars == TYPE_GGA) begin
                            result.kind    = KIND_GGA;
                            result.has_fix = nx.gga_ok;
                        end else if (nx.type_chars == TYPE_GSA) begin
                            result.kind    = KIND_GSA;
                            result.has_fix = nx.gsa_ok;
                        end
                    end
                    nx = '0;
                end
            end
        end

        st_next = nx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (step) begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== rtl/nsc_out_stage.sv =====
// ----------------------------------------------------------------------------
// nsc_out_stage
// Result register that holds one sentence result until the sink takes it.
// ----------------------------------------------------------------------------
module nsc_out_stage import nsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  result_t    result,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [1:0] m_sentence_kind,
    output logic       m_has_fix
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    assign m_valid         = valid_reg;
    assign m_status        = result_reg.status;
    assign m_sentence_kind = result_reg.kind;
    assign m_has_fix       = result_reg.has_fix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/nmea_sentence_checker_unit.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checker_unit
// Checks NMEA 0183 sentences byte by byte and reports status, sentence kind
// and fix flag for every sentence ended by a line feed within MAX_SENTENCE_LEN bytes.
//
//   Channel   Ports                                     Beat
//   input     s_valid s_ready s_rx_byte                 one received byte
//   result    m_valid m_ready m_status                  one checked sentence
//             m_sentence_kind m_has_fix
//
// A byte is held in the input register while the tracker works on it; the
// result of a line feed is registered in the result register and offered on
// the result channel from there. One byte per cycle is sustained while
// results are taken. Reset is synchronous and active low and returns the block
// to the idle state. A stalled result only holds back a line feed that would
// produce another one; other bytes keep flowing while the result waits.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_unit import nsc_pkg::*; #(
    parameter int MAX_SENTENCE_LEN = MAX_SENTENCE_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [1:0] m_sentence_kind,
    output logic       m_has_fix
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       emit;
    logic       out_free;
    logic       advance;
    result_t    result;

    assign advance = byte_valid && (!emit || out_free);

    nsc_rx_stage u_rx_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    nsc_tracker #(
        .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN)
    ) u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (byte_data),
        .emit    (emit),
        .result  (result)
    );

    nsc_out_stage u_out_stage (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (advance && emit),
        .result          (result),
        .free            (out_free),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_sentence_kind (m_sentence_kind),
        .m_has_fix       (m_has_fix)
    );

endmodule
